### rtl/pc_sample_histogram_core_defines.svh
// ----------------------------------------------------------------------------
// pc sample histogram core assertion macros
// immediate-implication and next-cycle forms, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef PC_SAMPLE_HISTOGRAM_CORE_DEFINES_SVH
`define PC_SAMPLE_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define PCSH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

### rtl/pcsh_pkg.sv
// ----------------------------------------------------------------------------
// pcsh_pkg
// shared types, codes and sizes of the pc sample histogram core
// ----------------------------------------------------------------------------
package pcsh_pkg;

	// histogram store
	localparam int unsigned ENTRIES  = 4096;
	localparam int          IDX_W    = $clog2(ENTRIES);
	localparam int          IN_IDX_W = 12;
	localparam int          AW_W     = (IDX_W > IN_IDX_W) ? IDX_W : IN_IDX_W;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// configuration registers
	localparam int                   CFG_IDX_W          = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_START     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_END       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT      = 2'd2;
	localparam logic [31:0]          CODE_START_RESET   = 32'h0000_8000;
	localparam logic [31:0]          CODE_END_RESET     = 32'h0000_C000;
	localparam logic [31:0]          MIN_COUNT_RESET    = 32'h0000_0000;

	// commands
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	// result status
	localparam logic [1:0] ST_COUNTED = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_READ    = 2'd2;

	typedef struct packed {
		logic                command;
		logic [31:0]         sample_pc;
		logic [IN_IDX_W-1:0] entry_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] entry_address;
		logic [31:0] entry_count;
		logic        above_threshold;
	} out_item_t;

	typedef struct packed {
		logic [31:0] code_start;
		logic [31:0] code_end;
		logic [31:0] min_count;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_IGNORE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	// classified work item
	typedef struct packed {
		op_t             op;
		logic [AW_W-1:0] addr_word;
		logic            in_store;
	} q_item_t;

	typedef struct packed {
		logic clearing;
	} back_status_t;

endpackage

### rtl/pcsh_front.sv
// ----------------------------------------------------------------------------
// pcsh_front
// accepts items, classifies samples against the code range and store size, and checks read indexes
// ----------------------------------------------------------------------------
module pcsh_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  pcsh_pkg::in_item_t    in_data,
	input  pcsh_pkg::cfg_t        cfg,
	input  pcsh_pkg::back_status_t bstat,
	input  logic                  q_full,
	output logic                  push,
	output pcsh_pkg::q_item_t     push_item
);
	import pcsh_pkg::*;

	logic [31:0] diff;
	logic [29:0] word;
	logic        in_range;
	logic        word_ok;
	logic        counted;
	logic        read_ok;

	assign in_ready = !q_full && !bstat.clearing;
	assign push     = in_valid && in_ready;

	assign in_range = (in_data.sample_pc >= cfg.code_start) &&
		(in_data.sample_pc < cfg.code_end);
	assign diff     = in_data.sample_pc - cfg.code_start;
	assign word     = diff[31:2];
	assign word_ok  = ({2'b00, word} < 32'(ENTRIES));
	assign counted  = in_range && word_ok;
	assign read_ok  = (32'(in_data.entry_index) < 32'(ENTRIES));

	always_comb begin
		push_item = '0;
		unique case (in_data.command)
			CMD_SAMPLE: begin
				push_item.op        = counted ? OP_COUNT : OP_IGNORE;
				push_item.addr_word = AW_W'(word);
				push_item.in_store  = counted;
			end
			CMD_READ: begin
				push_item.op        = OP_READ;
				push_item.addr_word = AW_W'(in_data.entry_index);
				push_item.in_store  = read_ok;
			end
		endcase
	end

endmodule

### rtl/pcsh_queue.sv
// ----------------------------------------------------------------------------
// pcsh_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module pcsh_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pcsh_pkg::q_item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output pcsh_pkg::q_item_t head_item
);
	import pcsh_pkg::*;

	q_item_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/pcsh_back.sv
// ----------------------------------------------------------------------------
// pcsh_back
// histogram store, read-modify-write with forwarding, result register
// ----------------------------------------------------------------------------
module pcsh_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcsh_pkg::cfg_t         cfg,
	input  logic                   q_valid,
	input  pcsh_pkg::q_item_t      q_item,
	output logic                   q_pop,
	output pcsh_pkg::back_status_t bstat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output pcsh_pkg::out_item_t    out_data
);
	import pcsh_pkg::*;

	logic [31:0]      mem [ENTRIES];
	logic [31:0]      rdata_q;

	logic             clr_busy_q;
	logic [IDX_W-1:0] clr_idx_q;

	logic             valid_s1;
	op_t              op_s1;
	logic [AW_W-1:0]  addr_word_s1;
	logic             in_store_s1;
	logic             fwd_s1;
	logic [31:0]      fwd_data_s1;

	logic             out_valid_q;
	out_item_t        out_data_q;

	logic             adv_s1;
	logic             wr_en;
	logic [IDX_W-1:0] idx_s1;
	logic [IDX_W-1:0] head_idx;
	logic [31:0]      base;
	logic [31:0]      inc;
	logic [31:0]      addr;
	logic [31:0]      cnt;
	out_item_t        res;

	assign bstat.clearing = clr_busy_q;
	assign out_valid      = out_valid_q;
	assign out_data       = out_data_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign q_pop    = q_valid && !clr_busy_q && (!valid_s1 || adv_s1);
	assign idx_s1   = IDX_W'(addr_word_s1);
	assign head_idx = IDX_W'(q_item.addr_word);

	// last write is not yet visible in the registered read
	assign base = fwd_s1 ? fwd_data_s1 : rdata_q;
	assign inc  = (base == COUNT_MAX) ? base : base + 32'd1;
	assign addr = cfg.code_start + 32'({addr_word_s1, 2'b00});

	always_comb begin
		res   = '0;
		cnt   = '0;
		wr_en = 1'b0;
		unique case (op_s1)
			OP_COUNT: begin
				res.status        = ST_COUNTED;
				res.entry_address = addr;
				cnt               = inc;
				wr_en             = adv_s1;
			end
			OP_IGNORE: begin
				res.status = ST_IGNORED;
			end
			OP_READ: begin
				res.status        = ST_READ;
				res.entry_address = addr;
				cnt               = in_store_s1 ? base : '0;
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
		res.entry_count     = cnt;
		res.above_threshold = (cnt > cfg.min_count);
	end

	// store: clearing sweep, count write-back, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[idx_s1] <= inc;
		end
		if (q_pop) begin
			rdata_q <= mem[head_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(ENTRIES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_s1        <= q_item.op;
			addr_word_s1 <= q_item.addr_word;
			in_store_s1  <= q_item.in_store;
			fwd_s1       <= wr_en && (idx_s1 == head_idx);
			fwd_data_s1  <= inc;
		end
		if (adv_s1) begin
			out_data_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/pc_sample_histogram_core.sv
// ----------------------------------------------------------------------------
// pc_sample_histogram_core
// pc sampling profiler histogram with entry readout
// ----------------------------------------------------------------------------
//
// channel   dir   handshake            payload
// in        in    in_valid/in_ready    in_data   (command, sample_pc, entry_index)
// out       out   out_valid/out_ready  out_data  (status, address, count, flag)
// cfg       in    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high and no clearing runs; a result
// passes the queue slot written at transfer, store read stage, result register
// the store keeps one read and one write a cycle; a count from the item just
// before is forwarded around the registered read
// after reset a clearing pass zeroes the store, with in_ready low while it runs;
// configuration writes are taken throughout
// a stalled output holds the result; the two-entry queue lets the front keep
// accepting until it fills
//
module pc_sample_histogram_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pcsh_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pcsh_pkg::out_item_t            out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pcsh_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import pcsh_pkg::*;

	// configuration registers
	cfg_t         cfg_q;

	// front to queue
	logic         push;
	q_item_t      push_item;
	logic         q_full;

	// queue to back
	logic         q_valid;
	q_item_t      q_item;
	logic         q_pop;

	back_status_t bstat;

	// registers always take a write; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_start <= CODE_START_RESET;
			cfg_q.code_end   <= CODE_END_RESET;
			cfg_q.min_count  <= MIN_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CODE_START: cfg_q.code_start <= cfg_data;
				CFG_CODE_END:   cfg_q.code_end   <= cfg_data;
				CFG_MIN_COUNT:  cfg_q.min_count  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// front: range check and word index
	pcsh_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.bstat     (bstat),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	pcsh_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_item)
	);

	// back: store update and result transfer
	pcsh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.bstat     (bstat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### rtl/pcsh_checker.sv
// ----------------------------------------------------------------------------
// pcsh_checker
// port-level checks of the pc sample histogram core
// ----------------------------------------------------------------------------
`include "pc_sample_histogram_core_defines.svh"

module pcsh_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input pcsh_pkg::out_item_t out_data
);
	import pcsh_pkg::*;

	// result held while stalled
	`PCSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

	// ignored sample carries no entry
	`PCSH_ASSERT_NOW(a_ignored_zero, out_valid && (out_data.status == ST_IGNORED), (out_data.entry_count == 32'd0) && (out_data.entry_address == 32'd0) && !out_data.above_threshold, "ignored sample with data")

	// a counted sample never shows a zero count
	`PCSH_ASSERT_NOW(a_counted_nonzero, out_valid && (out_data.status == ST_COUNTED), out_data.entry_count != 32'd0, "counted sample with zero count")

	// a zero count is never above the threshold
	`PCSH_ASSERT_NOW(a_zero_not_above, out_valid && (out_data.entry_count == 32'd0), !out_data.above_threshold, "zero count flagged above threshold")

endmodule

bind pc_sample_histogram_core pcsh_checker u_pcsh_checker (.*);
